[rtl/rfdr_pkg.sv]
package rfdr_pkg;

  localparam int WORD_W         = 32;
  localparam int ID_W           = 6;
  localparam int PART_W         = 2;
  localparam int HALF_W         = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int SLOT_W         = 1;

  localparam int HISTORY_DEPTH_DEF = 10;
  localparam int SENSOR_SLOTS_DEF  = 2;
  localparam int NUM_ID_REGS       = 2;

  localparam logic [ID_W-1:0] FIRST_ID_RST  = 6'd26;
  localparam logic [ID_W-1:0] SECOND_ID_RST = 6'd27;

  localparam logic [WORD_W-1:0] HASH_MUL1 = 32'h7feb352d;
  localparam logic [WORD_W-1:0] HASH_MUL2 = 32'h846ca68b;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ID = 1'd1;

  typedef enum logic [1:0] {
    ST_DUP     = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FIRST   = 2'd2,
    ST_RECORD  = 2'd3
  } status_t;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    logic              dup;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
  } item_t;

  // Queue handshake status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[rtl/rf_packet_dedup_reassembler_core.sv]
// Radio word dedup and reassembly. Each 32-bit word is checked against a
// history of the last HISTORY_DEPTH new words; a repeat yields status 0 with
// all other fields zero. New words are split into header (part number, sensor
// id), two data bytes and a check byte; the check byte is compared with the low
// byte of a lowbias32 hash and only flagged. Part 0 stores the data half of the
// matched sensor slot, other parts emit a record (stored half low, new half
// high); unknown ids get status 1. The front takes a word per cycle while its
// two-entry queue has room; the back steps each word through S_IDLE, S_MUL1,
// S_MUL2 (the two chained hash multiplies) and S_FIN, and pops the next word
// only from S_IDLE. A finished result waits in the output register while the
// back starts the next word. Write the sensor id registers only while idle.
module rf_packet_dedup_reassembler_core #(
  parameter int HISTORY_DEPTH = rfdr_pkg::HISTORY_DEPTH_DEF,
  parameter int SENSOR_SLOTS  = rfdr_pkg::SENSOR_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rfdr_pkg::WORD_W-1:0]    in_received_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [rfdr_pkg::SLOT_W-1:0]    out_sensor_slot,
  output logic [rfdr_pkg::ID_W-1:0]      out_sensor_id,
  output logic [rfdr_pkg::PART_W-1:0]    out_part_number,
  output logic [rfdr_pkg::WORD_W-1:0]    out_record_value,
  output logic                           out_hash_ok,
  input  logic                           cfg_we,
  input  logic [rfdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfdr_pkg::ID_W-1:0]      cfg_wdata
);
  import rfdr_pkg::*;

  queue_stat_t q_stat;
  item_t       push_item, pop_item;
  logic        push, pop;

  // Front: hold the history and id registers, classify each word, push it.
  rfdr_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SENSOR_SLOTS  (SENSOR_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_received_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Queue: decouple classification from the hash and reassembly work.
  rfdr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Back: hash, store or emit halves, drive the result register.
  rfdr_back #(
    .SENSOR_SLOTS (SENSOR_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .pop_item         (pop_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_sensor_slot  (out_sensor_slot),
    .out_sensor_id    (out_sensor_id),
    .out_part_number  (out_part_number),
    .out_record_value (out_record_value),
    .out_hash_ok      (out_hash_ok)
  );

endmodule

[rtl/rfdr_front.sv]
module rfdr_front #(
  parameter int HISTORY_DEPTH = rfdr_pkg::HISTORY_DEPTH_DEF,
  parameter int SENSOR_SLOTS  = rfdr_pkg::SENSOR_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rfdr_pkg::WORD_W-1:0]    in_word,
  input  logic                           cfg_we,
  input  logic [rfdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfdr_pkg::ID_W-1:0]      cfg_wdata,
  input  rfdr_pkg::queue_stat_t          q_stat,
  output logic                           push,
  output rfdr_pkg::item_t                push_item
);
  import rfdr_pkg::*;

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

  logic [ID_W-1:0]   first_id_r, second_id_r;
  logic [WORD_W-1:0] hist_word_r [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hist_valid_r;
  logic [PTR_W-1:0]  hist_ptr_r, hist_ptr_nxt;
  logic [HISTORY_DEPTH-1:0] hit_vec;
  logic              hit;
  logic              found;
  logic [SLOT_W-1:0] slot;
  logic [ID_W-1:0]   id;
  logic              accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign id       = in_word[29:24];

  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      hit_vec[i] = hist_valid_r[i] && (hist_word_r[i] == in_word);
    end
  end
  assign hit = |hit_vec;

  // Lowest matching slot wins; only slots backed by a register can match.
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = 0; i < SENSOR_SLOTS && i < NUM_ID_REGS; i++) begin
      if (!found && (((i == 0) && (first_id_r == id)) ||
                     ((i == 1) && (second_id_r == id)))) begin
        found = 1'b1;
        slot  = SLOT_W'(i);
      end
    end
  end

  assign hist_ptr_nxt = (hist_ptr_r == PTR_LAST) ? '0 : hist_ptr_r + 1'b1;

  assign push              = accept;
  assign push_item.dup     = hit;
  assign push_item.found   = found && !hit;
  assign push_item.slot    = (found && !hit) ? slot : '0;
  assign push_item.word    = in_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_id_r   <= FIRST_ID_RST;
      second_id_r  <= SECOND_ID_RST;
      hist_valid_r <= '0;
      hist_ptr_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_ID:  first_id_r  <= cfg_wdata;
          CFG_SECOND_ID: second_id_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && !hit) begin
        hist_valid_r[hist_ptr_r] <= 1'b1;
        hist_ptr_r               <= hist_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !hit) begin
      hist_word_r[hist_ptr_r] <= in_word;
    end
  end

endmodule

[rtl/rfdr_queue.sv]
module rfdr_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rfdr_pkg::item_t       push_item,
  input  logic                  pop,
  output rfdr_pkg::item_t       pop_item,
  output rfdr_pkg::queue_stat_t q_stat
);
  import rfdr_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_item     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

[rtl/rfdr_back.sv]
module rfdr_back #(
  parameter int SENSOR_SLOTS = rfdr_pkg::SENSOR_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rfdr_pkg::queue_stat_t       q_stat,
  input  rfdr_pkg::item_t             pop_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [rfdr_pkg::SLOT_W-1:0] out_sensor_slot,
  output logic [rfdr_pkg::ID_W-1:0]   out_sensor_id,
  output logic [rfdr_pkg::PART_W-1:0] out_part_number,
  output logic [rfdr_pkg::WORD_W-1:0] out_record_value,
  output logic                        out_hash_ok
);
  import rfdr_pkg::*;

  localparam int SIDX_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL1 = 4'b0010,
    S_MUL2 = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  item_t             work_r;
  logic [WORD_W-1:0] prod_r, prod_nxt;
  logic [HALF_W-1:0] pending_r [SENSOR_SLOTS];
  logic              out_valid_r;
  logic [1:0]        status_r;
  logic [SLOT_W-1:0] slot_r;
  logic [ID_W-1:0]   id_r;
  logic [PART_W-1:0] part_r;
  logic [WORD_W-1:0] record_r;
  logic              ok_r;

  logic [WORD_W-1:0] hash_in, mix1, mix2, hash;
  logic [HALF_W-1:0] half;
  logic [SIDX_W-1:0] sidx;
  logic [PART_W-1:0] part;
  logic              fin_go;
  status_t           status;

  assign hash_in = {8'h00, work_r.word[15:8], work_r.word[23:16], work_r.word[31:24]};
  assign mix1    = hash_in ^ (hash_in >> 16);
  assign mix2    = prod_r ^ (prod_r >> 15);
  assign hash    = prod_r ^ (prod_r >> 16);
  assign half    = {work_r.word[15:8], work_r.word[23:16]};
  assign part    = work_r.word[31:30];
  assign sidx    = SIDX_W'(work_r.slot);
  assign fin_go  = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign pop     = (state_r == S_IDLE) && !q_stat.empty;

  always_comb begin
    if (work_r.dup)            status = ST_DUP;
    else if (!work_r.found)    status = ST_UNKNOWN;
    else if (part == 2'd0)     status = ST_FIRST;
    else                       status = ST_RECORD;
  end

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    case (state_r)
      S_IDLE: if (!q_stat.empty) state_nxt = S_MUL1;
      S_MUL1: begin
        prod_nxt  = mix1 * HASH_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        prod_nxt  = mix2 * HASH_MUL2;
        state_nxt = S_FIN;
      end
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go)                  out_valid_r <= 1'b1;
      else if (out_ready)          out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (pop) work_r <= pop_item;
    if (fin_go) begin
      status_r <= status;
      if (work_r.dup) begin
        slot_r   <= '0;
        id_r     <= '0;
        part_r   <= '0;
        record_r <= '0;
        ok_r     <= 1'b0;
      end else begin
        slot_r   <= work_r.slot;
        id_r     <= work_r.word[29:24];
        part_r   <= part;
        record_r <= (status == ST_RECORD) ? {half, pending_r[sidx]} : '0;
        ok_r     <= (hash[7:0] == work_r.word[7:0]);
      end
      if (status == ST_FIRST) pending_r[sidx] <= half;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_sensor_slot  = slot_r;
  assign out_sensor_id    = id_r;
  assign out_part_number  = part_r;
  assign out_record_value = record_r;
  assign out_hash_ok      = ok_r;

endmodule
